// ===== src/doubly_linked_list_manager_defines.svh =====
// Assertion macros used by the list manager port checker.
`ifndef DOUBLY_LINKED_LIST_MANAGER_DEFINES_SVH
`define DOUBLY_LINKED_LIST_MANAGER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DLL_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DLL_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/dll_pkg.sv =====
// Shared constants, codes and memory request types of the linked list manager.
package dll_pkg;

	localparam int NODE_SLOTS   = 32;
	localparam int SLOT_W       = $clog2(NODE_SLOTS);
	localparam int LINK_W       = SLOT_W + 1;
	localparam int PAYLOAD_BITS = 32;
	localparam int NODE_W       = LINK_W + PAYLOAD_BITS;

	// link value meaning "no slot"
	localparam logic [LINK_W-1:0] NO_SLOT = LINK_W'(NODE_SLOTS);
	// node word is {prev, payload}; this mask selects the prev field
	localparam logic [NODE_W-1:0] PREV_MASK = {{LINK_W{1'b1}}, {PAYLOAD_BITS{1'b0}}};

	typedef enum logic [2:0] {
		CMD_INSERT  = 3'd0,
		CMD_APPEND  = 3'd1,
		CMD_REMOVE  = 3'd2,
		CMD_INSPECT = 3'd3,
		CMD_DESTROY = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_LINKED     = 2'd1,
		STAT_NOT_LINKED = 2'd2,
		STAT_NO_ANCHOR  = 2'd3
	} status_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] waddr;
		logic [LINK_W-1:0] wdata;
		logic              re;
		logic [SLOT_W-1:0] raddr;
	} next_req_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] waddr;
		logic [NODE_W-1:0] wdata;
		logic [NODE_W-1:0] wmask;
		logic              re;
		logic [SLOT_W-1:0] raddr;
	} node_req_t;

endpackage

// ===== src/doubly_linked_list_manager.sv =====
// Errors, an empty-list insert, inspect misses and empty destroy finish in the execute state;
// head insert adds a prev write-back to the old head; remove and inspect read the slot's
// links first; insert after an anchor and append read the anchor's next link, then do two
// link write-backs. One item at a time; destroy gives one result per cycle while the output
// is not stalled. Reset clears the linked flags, head, tail and count; link and payload
// memories are not cleared, since only linked slots are ever read.
module doubly_linked_list_manager (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [2:0]                       command,
	input  logic [dll_pkg::SLOT_W-1:0]       node_slot,
	input  logic [dll_pkg::SLOT_W-1:0]       anchor_slot,
	input  logic                             anchor_present,
	input  logic [dll_pkg::PAYLOAD_BITS-1:0] payload,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [1:0]                       status,
	output logic [dll_pkg::PAYLOAD_BITS-1:0] payload_out,
	output logic [dll_pkg::SLOT_W-1:0]       slot_out,
	output logic [dll_pkg::LINK_W-1:0]       next_out,
	output logic [dll_pkg::LINK_W-1:0]       prev_out,
	output logic [dll_pkg::LINK_W-1:0]       head_out,
	output logic [dll_pkg::LINK_W-1:0]       tail_out,
	output logic [dll_pkg::LINK_W-1:0]       count_out,
	output logic                             last
);

	// Two memories hold the list:
	//   next memory : next link per slot
	//   node memory : {prev link, payload} per slot, prev field writable on its own
	// Splitting next from prev lets every unlink write both neighbors in the same cycle: the
	// predecessor's next and the successor's prev land in different memories.
	dll_pkg::next_req_t                next_req;
	dll_pkg::node_req_t                node_req;
	logic [dll_pkg::LINK_W-1:0]        next_rdata;
	logic [dll_pkg::NODE_W-1:0]        node_rdata;

	// The sequencer owns the linked flags, head/tail/count and the result register.
	// A finished result waits in that register while the next item is taken in;
	// the sequencer only stalls when it must load a new result into a full register.
	dll_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.node_slot      (node_slot),
		.anchor_slot    (anchor_slot),
		.anchor_present (anchor_present),
		.payload        (payload),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.payload_out    (payload_out),
		.slot_out       (slot_out),
		.next_out       (next_out),
		.prev_out       (prev_out),
		.head_out       (head_out),
		.tail_out       (tail_out),
		.count_out      (count_out),
		.last           (last),
		.next_req       (next_req),
		.next_rdata     (next_rdata),
		.node_req       (node_req),
		.node_rdata     (node_rdata)
	);

	// Next-link memory: written full-width, no mask needed.
	dll_ram #(
		.DEPTH (dll_pkg::NODE_SLOTS),
		.WIDTH (dll_pkg::LINK_W)
	) u_next_ram (
		.clk   (clk),
		.we    (next_req.we),
		.waddr (next_req.waddr),
		.wdata (next_req.wdata),
		.wmask ({dll_pkg::LINK_W{1'b1}}),
		.re    (next_req.re),
		.raddr (next_req.raddr),
		.rdata (next_rdata)
	);

	// Node memory: prev link and payload; neighbor updates touch the prev field only.
	dll_ram #(
		.DEPTH (dll_pkg::NODE_SLOTS),
		.WIDTH (dll_pkg::NODE_W)
	) u_node_ram (
		.clk   (clk),
		.we    (node_req.we),
		.waddr (node_req.waddr),
		.wdata (node_req.wdata),
		.wmask (node_req.wmask),
		.re    (node_req.re),
		.raddr (node_req.raddr),
		.rdata (node_rdata)
	);

endmodule

// ===== src/dll_ram.sv =====
// Generic single-write, single-read synchronous RAM with bit write mask.
module dll_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [WIDTH-1:0]         wmask,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			for (int i = 0; i < WIDTH; i++) begin
				if (wmask[i]) begin
					mem[waddr][i] <= wdata[i];
				end
			end
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/dll_ctrl.sv =====
// Command sequencer: link flags, head/tail/count, memory accesses, result register.
module dll_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [2:0]                      command,
	input  logic [dll_pkg::SLOT_W-1:0]      node_slot,
	input  logic [dll_pkg::SLOT_W-1:0]      anchor_slot,
	input  logic                            anchor_present,
	input  logic [dll_pkg::PAYLOAD_BITS-1:0] payload,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      status,
	output logic [dll_pkg::PAYLOAD_BITS-1:0] payload_out,
	output logic [dll_pkg::SLOT_W-1:0]      slot_out,
	output logic [dll_pkg::LINK_W-1:0]      next_out,
	output logic [dll_pkg::LINK_W-1:0]      prev_out,
	output logic [dll_pkg::LINK_W-1:0]      head_out,
	output logic [dll_pkg::LINK_W-1:0]      tail_out,
	output logic [dll_pkg::LINK_W-1:0]      count_out,
	output logic                            last,
	output dll_pkg::next_req_t              next_req,
	input  logic [dll_pkg::LINK_W-1:0]      next_rdata,
	output dll_pkg::node_req_t              node_req,
	input  logic [dll_pkg::NODE_W-1:0]      node_rdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_HEAD2,
		ST_INS1,
		ST_INS2,
		ST_UNLINK,
		ST_DESTROY
	} state_t;

	state_t                             state_q, state_d;
	logic [dll_pkg::NODE_SLOTS-1:0]     linked_q, linked_d;
	logic [dll_pkg::LINK_W-1:0]         head_q, head_d;
	logic [dll_pkg::LINK_W-1:0]         tail_q, tail_d;
	logic [dll_pkg::LINK_W-1:0]         count_q, count_d;
	logic                               out_valid_q;

	logic [2:0]                         cmd_q;
	logic [dll_pkg::SLOT_W-1:0]         slot_q;
	logic [dll_pkg::SLOT_W-1:0]         anchor_q;
	logic                               anchor_present_q;
	logic [dll_pkg::PAYLOAD_BITS-1:0]   pay_q;

	logic [1:0]                         status_q;
	logic [dll_pkg::PAYLOAD_BITS-1:0]   payload_out_q;
	logic [dll_pkg::SLOT_W-1:0]         slot_out_q;
	logic [dll_pkg::LINK_W-1:0]         next_out_q;
	logic [dll_pkg::LINK_W-1:0]         prev_out_q;
	logic [dll_pkg::LINK_W-1:0]         head_out_q;
	logic [dll_pkg::LINK_W-1:0]         tail_out_q;
	logic [dll_pkg::LINK_W-1:0]         count_out_q;
	logic                               last_q;

	logic                               emit;
	dll_pkg::status_t                   e_status;
	logic [dll_pkg::PAYLOAD_BITS-1:0]   e_pay;
	logic [dll_pkg::SLOT_W-1:0]         e_slot;
	logic [dll_pkg::LINK_W-1:0]         e_next;
	logic [dll_pkg::LINK_W-1:0]         e_prev;
	logic                               e_last;

	logic                               out_free;
	logic                               slot_linked;
	logic                               anchor_linked;
	dll_pkg::status_t                   ins_status;
	logic [dll_pkg::SLOT_W-1:0]         ins_anchor;
	logic [dll_pkg::LINK_W-1:0]         nx_rd;
	logic [dll_pkg::LINK_W-1:0]         pv_rd;
	logic [dll_pkg::PAYLOAD_BITS-1:0]   pay_rd;
	logic [dll_pkg::SLOT_W-1:0]         tail_idx;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	assign slot_linked = (dll_pkg::LINK_W'(slot_q) < dll_pkg::LINK_W'(dll_pkg::NODE_SLOTS))
		&& linked_q[slot_q];
	assign anchor_linked = (dll_pkg::LINK_W'(anchor_q) < dll_pkg::LINK_W'(dll_pkg::NODE_SLOTS))
		&& linked_q[anchor_q];

	assign nx_rd    = next_rdata;
	assign pv_rd    = node_rdata[dll_pkg::NODE_W-1 -: dll_pkg::LINK_W];
	assign pay_rd   = node_rdata[dll_pkg::PAYLOAD_BITS-1:0];
	assign tail_idx = tail_q[dll_pkg::SLOT_W-1:0];

	// append links after the current tail
	assign ins_anchor = (cmd_q == dll_pkg::CMD_APPEND) ? tail_idx : anchor_q;

	always_comb begin
		if (dll_pkg::LINK_W'(slot_q) >= dll_pkg::LINK_W'(dll_pkg::NODE_SLOTS)) begin
			ins_status = dll_pkg::STAT_NOT_LINKED;
		end else if (linked_q[slot_q]) begin
			ins_status = dll_pkg::STAT_LINKED;
		end else if (cmd_q == dll_pkg::CMD_INSERT && anchor_present_q && !anchor_linked) begin
			ins_status = dll_pkg::STAT_NO_ANCHOR;
		end else begin
			ins_status = dll_pkg::STAT_OK;
		end
	end

	always_comb begin
		state_d  = state_q;
		linked_d = linked_q;
		head_d   = head_q;
		tail_d   = tail_q;
		count_d  = count_q;
		emit     = 1'b0;
		e_status = dll_pkg::STAT_OK;
		e_pay    = '0;
		e_slot   = slot_q;
		e_next   = dll_pkg::NO_SLOT;
		e_prev   = dll_pkg::NO_SLOT;
		e_last   = 1'b1;
		next_req = '0;
		node_req = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (cmd_q)
					dll_pkg::CMD_INSERT, dll_pkg::CMD_APPEND: begin
						if (ins_status != dll_pkg::STAT_OK) begin
							if (out_free) begin
								emit     = 1'b1;
								e_status = ins_status;
								state_d  = ST_IDLE;
							end
						end else if (count_q == '0) begin
							// first node: both links empty
							if (out_free) begin
								next_req.we     = 1'b1;
								next_req.waddr  = slot_q;
								next_req.wdata  = dll_pkg::NO_SLOT;
								node_req.we     = 1'b1;
								node_req.waddr  = slot_q;
								node_req.wdata  = {dll_pkg::NO_SLOT, pay_q};
								node_req.wmask  = '1;
								linked_d[slot_q] = 1'b1;
								head_d  = dll_pkg::LINK_W'(slot_q);
								tail_d  = dll_pkg::LINK_W'(slot_q);
								count_d = dll_pkg::LINK_W'(1);
								emit    = 1'b1;
								state_d = ST_IDLE;
							end
						end else if (cmd_q == dll_pkg::CMD_INSERT && !anchor_present_q) begin
							next_req.we    = 1'b1;
							next_req.waddr = slot_q;
							next_req.wdata = head_q;
							node_req.we    = 1'b1;
							node_req.waddr = slot_q;
							node_req.wdata = {dll_pkg::NO_SLOT, pay_q};
							node_req.wmask = '1;
							state_d = ST_HEAD2;
						end else begin
							next_req.re    = 1'b1;
							next_req.raddr = ins_anchor;
							state_d = ST_INS1;
						end
					end
					dll_pkg::CMD_REMOVE, dll_pkg::CMD_INSPECT: begin
						if (!slot_linked) begin
							if (out_free) begin
								emit     = 1'b1;
								e_status = dll_pkg::STAT_NOT_LINKED;
								state_d  = ST_IDLE;
							end
						end else begin
							next_req.re    = 1'b1;
							next_req.raddr = slot_q;
							node_req.re    = 1'b1;
							node_req.raddr = slot_q;
							state_d = ST_UNLINK;
						end
					end
					dll_pkg::CMD_DESTROY: begin
						if (count_q == '0) begin
							if (out_free) begin
								emit    = 1'b1;
								e_slot  = '0;
								state_d = ST_IDLE;
							end
						end else begin
							node_req.re    = 1'b1;
							node_req.raddr = tail_idx;
							state_d = ST_DESTROY;
						end
					end
					default: begin
						if (out_free) begin
							emit    = 1'b1;
							e_slot  = '0;
							state_d = ST_IDLE;
						end
					end
				endcase
			end
			ST_HEAD2: begin
				if (out_free) begin
					node_req.we    = 1'b1;
					node_req.waddr = head_q[dll_pkg::SLOT_W-1:0];
					node_req.wdata = {dll_pkg::LINK_W'(slot_q), dll_pkg::PAYLOAD_BITS'(0)};
					node_req.wmask = dll_pkg::PREV_MASK;
					linked_d[slot_q] = 1'b1;
					head_d  = dll_pkg::LINK_W'(slot_q);
					count_d = count_q + dll_pkg::LINK_W'(1);
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_INS1: begin
				next_req.we    = 1'b1;
				next_req.waddr = slot_q;
				next_req.wdata = nx_rd;
				node_req.we    = 1'b1;
				node_req.waddr = slot_q;
				node_req.wdata = {dll_pkg::LINK_W'(ins_anchor), pay_q};
				node_req.wmask = '1;
				state_d = ST_INS2;
			end
			ST_INS2: begin
				if (out_free) begin
					next_req.we    = 1'b1;
					next_req.waddr = ins_anchor;
					next_req.wdata = dll_pkg::LINK_W'(slot_q);
					if (nx_rd == dll_pkg::NO_SLOT) begin
						tail_d = dll_pkg::LINK_W'(slot_q);
					end else begin
						node_req.we    = 1'b1;
						node_req.waddr = nx_rd[dll_pkg::SLOT_W-1:0];
						node_req.wdata = {dll_pkg::LINK_W'(slot_q), dll_pkg::PAYLOAD_BITS'(0)};
						node_req.wmask = dll_pkg::PREV_MASK;
					end
					linked_d[slot_q] = 1'b1;
					count_d = count_q + dll_pkg::LINK_W'(1);
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_UNLINK: begin
				if (out_free) begin
					emit    = 1'b1;
					e_pay   = pay_rd;
					state_d = ST_IDLE;
					if (cmd_q == dll_pkg::CMD_INSPECT) begin
						e_next = nx_rd;
						e_prev = pv_rd;
					end else begin
						if (pv_rd == dll_pkg::NO_SLOT) begin
							head_d = nx_rd;
						end else begin
							next_req.we    = 1'b1;
							next_req.waddr = pv_rd[dll_pkg::SLOT_W-1:0];
							next_req.wdata = nx_rd;
						end
						if (nx_rd == dll_pkg::NO_SLOT) begin
							tail_d = pv_rd;
						end else begin
							node_req.we    = 1'b1;
							node_req.waddr = nx_rd[dll_pkg::SLOT_W-1:0];
							node_req.wdata = {pv_rd, dll_pkg::PAYLOAD_BITS'(0)};
							node_req.wmask = dll_pkg::PREV_MASK;
						end
						linked_d[slot_q] = 1'b0;
						count_d = count_q - dll_pkg::LINK_W'(1);
					end
				end
			end
			ST_DESTROY: begin
				// one tail node per cycle while the output is not stalled; the prev read of the new tail overlaps
				if (out_free) begin
					if (pv_rd == dll_pkg::NO_SLOT) begin
						head_d  = dll_pkg::NO_SLOT;
						state_d = ST_IDLE;
					end else begin
						next_req.we    = 1'b1;
						next_req.waddr = pv_rd[dll_pkg::SLOT_W-1:0];
						next_req.wdata = dll_pkg::NO_SLOT;
						node_req.re    = 1'b1;
						node_req.raddr = pv_rd[dll_pkg::SLOT_W-1:0];
					end
					tail_d  = pv_rd;
					count_d = count_q - dll_pkg::LINK_W'(1);
					linked_d[tail_idx] = 1'b0;
					emit   = 1'b1;
					e_pay  = pay_rd;
					e_slot = tail_idx;
					e_last = (pv_rd == dll_pkg::NO_SLOT);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			linked_q    <= '0;
			head_q      <= dll_pkg::NO_SLOT;
			tail_q      <= dll_pkg::NO_SLOT;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			linked_q <= linked_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			count_q  <= count_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item and result payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			cmd_q            <= command;
			slot_q           <= node_slot;
			anchor_q         <= anchor_slot;
			anchor_present_q <= anchor_present;
			pay_q            <= payload;
		end
		if (emit) begin
			status_q      <= e_status;
			payload_out_q <= e_pay;
			slot_out_q    <= e_slot;
			next_out_q    <= e_next;
			prev_out_q    <= e_prev;
			head_out_q    <= head_d;
			tail_out_q    <= tail_d;
			count_out_q   <= count_d;
			last_q        <= e_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign payload_out = payload_out_q;
	assign slot_out    = slot_out_q;
	assign next_out    = next_out_q;
	assign prev_out    = prev_out_q;
	assign head_out    = head_out_q;
	assign tail_out    = tail_out_q;
	assign count_out   = count_out_q;
	assign last        = last_q;

endmodule

// ===== src/dll_checker.sv =====
// Port-level checker for the list manager, bound to the top level.
`include "doubly_linked_list_manager_defines.svh"

module dll_port_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [1:0]                       status,
	input logic [dll_pkg::PAYLOAD_BITS-1:0] payload_out,
	input logic [dll_pkg::SLOT_W-1:0]       slot_out,
	input logic [dll_pkg::LINK_W-1:0]       head_out,
	input logic [dll_pkg::LINK_W-1:0]       tail_out,
	input logic [dll_pkg::LINK_W-1:0]       count_out,
	input logic                             last
);

	`DLL_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(payload_out) && $stable(slot_out) && $stable(last), "result changed while stalled")

	`DLL_ASSERT_IMPL(a_empty_count, clk, arst_n, out_valid, (count_out == '0) == (head_out == dll_pkg::NO_SLOT), "count and head disagree on empty list")

	`DLL_ASSERT_IMPL(a_head_tail, clk, arst_n, out_valid, (head_out == dll_pkg::NO_SLOT) == (tail_out == dll_pkg::NO_SLOT), "head and tail disagree on empty list")

	`DLL_ASSERT_IMPL(a_err_last, clk, arst_n, out_valid && (status != dll_pkg::STAT_OK), last, "error result not final")

endmodule

bind doubly_linked_list_manager dll_port_checker u_dll_checker (.*);
